[rtl/kmhd_pkg.sv]
`timescale 1ns / 1ps
// kmhd_pkg: matrix geometry, field widths, register indexes and reset values
// for the key matrix history debouncer; no dependencies
package kmhd_pkg;

  localparam int ROWS       = 4;
  localparam int COLS       = 11;
  localparam int FIELD_COLS = 11;
  localparam int ROW_W      = 2;
  localparam int HIST_W     = 8;
  localparam int CNT_W      = 6;
  localparam int THR_W      = 8;
  localparam int KW         = (COLS > FIELD_COLS) ? COLS : FIELD_COLS;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 16;
  localparam int CIDX_W = 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [FIELD_COLS-1:0] LIVE_MASK =
    (COLS >= FIELD_COLS) ? {FIELD_COLS{1'b1}} : FIELD_COLS'((1 << COLS) - 1);

  localparam logic [THR_W-1:0] DOWN_THR_RST = 8'd240;
  localparam logic [THR_W-1:0] UP_THR_RST   = 8'd15;

  localparam logic [CIDX_W-1:0] REG_DOWN_THR = 1'd0;
  localparam logic [CIDX_W-1:0] REG_UP_THR   = 1'd1;

  localparam logic MODE_ROW   = 1'b0;
  localparam logic MODE_PROBE = 1'b1;

  typedef logic [COLS-1:0][HIST_W-1:0] row_hist_t;
  typedef logic [FIELD_COLS-1:0]       row_keys_t;

endpackage

[rtl/key_matrix_history_debounce.sv]
`timescale 1ns / 1ps
// key_matrix_history_debounce: per-key shift-register debounce with idle detection
// the result is registered when an item is accepted and is valid in the next cycle
// throughput: one item per cycle while the output is not stalled; per-row history update and compares are one pass
// in_tready drops only while a result waits and out_tready is low
// reset (synchronous, rst_n low): histories, debounced rows, busy count and flags
// cleared, thresholds back to 240 and 15, output register empty
// depends on kmhd_pkg
module key_matrix_history_debounce (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [kmhd_pkg::IN_W-1:0]    in_tdata,   // row_index, column_levels
  input  logic                         in_tuser,   // mode
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [kmhd_pkg::OUT_W-1:0]   out_tdata,  // out_row, row_keys, idle_now, rescan_wanted
  output logic                         out_tlast,  // scan_done
  input  logic                         cfg_we,
  input  logic [kmhd_pkg::CIDX_W-1:0]  cfg_addr,
  input  logic [kmhd_pkg::THR_W-1:0]   cfg_wdata
);
  import kmhd_pkg::*;

  row_hist_t              hist_r [ROWS];
  row_keys_t              keys_r [ROWS];
  logic [CNT_W-1:0]       busy_cnt_r, busy_cnt_nxt;
  logic                   idle_r, idle_nxt;
  logic                   first_r, first_nxt;
  logic [THR_W-1:0]       down_thr_r, up_thr_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]       o_row_r, o_row_nxt;
  row_keys_t              o_keys_r, o_keys_nxt;
  logic                   o_done_r, o_done_nxt;
  logic                   o_rescan_r, o_rescan_nxt;

  logic                   in_fire;
  logic                   mode;
  logic [ROW_W-1:0]       row;
  row_keys_t              lev;
  logic [KW-1:0]          lev_w;
  logic [KW-1:0]          keys_w;
  row_hist_t              hist_new;
  logic [COLS-1:0]        busy;
  logic [CNT_W:0]         cnt_sum;
  logic [CNT_W-1:0]       cnt_sat;
  logic                   row_ok;
  logic                   upd_row;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign mode      = in_tuser;
  assign row       = in_tdata[ROW_W-1:0];
  assign lev       = in_tdata[ROW_W +: FIELD_COLS] & LIVE_MASK;
  assign lev_w     = KW'(lev);
  assign row_ok    = (int'(row) < ROWS);

  // per-key history shift and threshold compare for the addressed row
  always_comb begin
    keys_w = KW'(keys_r[row]);
    for (int c = 0; c < COLS; c++) begin
      hist_new[c] = {lev_w[c], hist_r[row][c][HIST_W-1:1]};
      busy[c]     = 1'b1;
      if (hist_new[c] >= down_thr_r) begin
        keys_w[c] = 1'b1;
      end else if (hist_new[c] <= up_thr_r) begin
        keys_w[c] = 1'b0;
        if (hist_new[c] == '0) begin
          busy[c] = 1'b0;
        end
      end
    end
    cnt_sum = {1'b0, busy_cnt_r} + (CNT_W+1)'($countones(busy));
    cnt_sat = (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_sum[CNT_W-1:0];
  end

  always_comb begin
    busy_cnt_nxt = busy_cnt_r;
    idle_nxt     = idle_r;
    first_nxt    = first_r;
    upd_row      = 1'b0;
    o_row_nxt    = '0;
    o_keys_nxt   = '0;
    o_done_nxt   = 1'b0;
    o_rescan_nxt = 1'b0;
    if (mode == MODE_PROBE) begin
      if (idle_r && (lev != '0)) begin
        idle_nxt  = 1'b0;
        first_nxt = 1'b1;
      end
    end else if (!row_ok) begin
      o_row_nxt = row;
    end else if (idle_r) begin
      o_row_nxt  = row;
      o_keys_nxt = keys_r[row];
    end else begin
      upd_row      = 1'b1;
      o_row_nxt    = row;
      o_keys_nxt   = keys_w[FIELD_COLS-1:0];
      busy_cnt_nxt = cnt_sat;
      if (int'(row) == ROWS - 1) begin
        o_done_nxt   = 1'b1;
        busy_cnt_nxt = '0;
        if (cnt_sat == '0) begin
          idle_nxt = 1'b1;
        end else if (first_r) begin
          first_nxt    = 1'b0;
          o_rescan_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        hist_r[r] <= '0;
        keys_r[r] <= '0;
      end
      busy_cnt_r  <= '0;
      idle_r      <= 1'b0;
      first_r     <= 1'b0;
      down_thr_r  <= DOWN_THR_RST;
      up_thr_r    <= UP_THR_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        busy_cnt_r <= busy_cnt_nxt;
        idle_r     <= idle_nxt;
        first_r    <= first_nxt;
        if (upd_row) begin
          hist_r[row] <= hist_new;
          keys_r[row] <= keys_w[FIELD_COLS-1:0];
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_DOWN_THR: down_thr_r <= cfg_wdata;
          REG_UP_THR:   up_thr_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      o_row_r    <= o_row_nxt;
      o_keys_r   <= o_keys_nxt;
      o_done_r   <= o_done_nxt;
      o_rescan_r <= o_rescan_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_done_r;
  assign out_tdata  = OUT_W'({o_rescan_r, idle_r, o_keys_r, o_row_r});

endmodule

[rtl/kmhd_checker.sv]
`timescale 1ns / 1ps
// kmhd_checker: port-level assertions for key_matrix_history_debounce
// depends on kmhd_pkg; bound to the top level below
module kmhd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [kmhd_pkg::OUT_W-1:0]   out_tdata,
  input logic                         out_tlast
);
  import kmhd_pkg::*;

  localparam int IDLE_BIT   = ROW_W + FIELD_COLS;
  localparam int RESCAN_BIT = ROW_W + FIELD_COLS + 1;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // input only blocked by a waiting result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // every accepted item gives a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item produced no result");

  // rescan only at the end of a busy scan
  a_rescan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[RESCAN_BIT] |-> out_tlast && !out_tdata[IDLE_BIT])
    else $error("rescan outside a busy scan end");

  // output register empty after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind key_matrix_history_debounce kmhd_checker u_kmhd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
